/* design/ufmst_pkg.sv */
// ----------------------------------------------------------------------------
// ufmst_pkg
// Request and result types and fixed widths for the union-find MST core.
// ----------------------------------------------------------------------------
package ufmst_pkg;

  localparam int NODE_BITS   = 6;
  localparam int WIN_BITS    = 16;
  localparam int TOTAL_BITS  = 32;
  localparam int COUNT_BITS  = 6;

  localparam logic [NODE_BITS-1:0]  NODE_COUNT_RESET = 6'd63;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX        = 6'd63;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX        = 32'hFFFF_FFFF;

  localparam logic MODE_EDGE  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [NODE_BITS-1:0] node_a;
    logic [NODE_BITS-1:0] node_b;
    logic [WIN_BITS-1:0]  weight;
  } request_t;

  typedef struct packed {
    logic                  joined;
    logic [TOTAL_BITS-1:0] total_weight;
    logic [COUNT_BITS-1:0] edges_taken;
    logic                  bad_node;
  } result_t;

endpackage

/* design/union_find_mst_accumulator.sv */
// ----------------------------------------------------------------------------
// union_find_mst_accumulator
// Kruskal MST core: disjoint-set forest with path compression, one parent
// memory (one write, one registered read per cycle) walked by a sequencer.
// ----------------------------------------------------------------------------
// Edge request: finds each root, one read per find step, then compresses each
// path, one read and one write per step. Clear request: sweeps every parent.
// Bad-endpoint request: answered from idle without raising busy.
// One request at a time; busy is high until the result strobe cycle.
// Reset: a sweep restores every parent to itself, busy meanwhile;
// total and count clear at once. done is a one-cycle strobe, never stalled.
module union_find_mst_accumulator #(
  parameter int NODES       = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  ufmst_pkg::request_t                  request,
  output logic                                 done,
  output ufmst_pkg::result_t                   result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ufmst_pkg::NODE_BITS-1:0]      cfg_data
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [AW-1:0] LAST = AW'(NODES - 1);
  localparam logic [ufmst_pkg::WIN_BITS-1:0] WMASK =
    (WEIGHT_BITS >= ufmst_pkg::WIN_BITS) ? {ufmst_pkg::WIN_BITS{1'b1}} :
    (ufmst_pkg::WIN_BITS)'((33'd1 << WEIGHT_BITS) - 33'd1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_FIND = 3'd2;
  localparam logic [2:0] S_FCHK = 3'd3;
  localparam logic [2:0] S_CRD  = 3'd4;
  localparam logic [2:0] S_CWR  = 3'd5;
  localparam logic [2:0] S_LINK = 3'd6;

  logic [2:0]                             state;
  logic                                   side;
  logic                                   clr_item;
  logic [AW-1:0]                          cur;
  logic [AW-1:0]                          walk;
  logic [AW-1:0]                          root_a;
  logic [AW-1:0]                          addr_b;
  logic [ufmst_pkg::WIN_BITS-1:0]         wt;
  logic [ufmst_pkg::NODE_BITS-1:0]        node_count;
  logic [ufmst_pkg::TOTAL_BITS-1:0]       total;
  logic [ufmst_pkg::COUNT_BITS-1:0]       count;
  logic                                   joined;
  logic                                   bad;

  logic [AW-1:0] parent_mem [NODES];
  logic [AW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] wdata;

  logic [ufmst_pkg::TOTAL_BITS:0] sum;
  logic                           accept;
  logic                           ok_a;
  logic                           ok_b;
  logic                           done_next;

  function automatic logic node_ok(input logic [ufmst_pkg::NODE_BITS-1:0] n,
                                   input logic [ufmst_pkg::NODE_BITS-1:0] lim);
    node_ok = (n != '0) && (n <= lim) && (32'(n) < NODES);
  endfunction

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign ok_a      = node_ok(request.node_a, node_count);
  assign ok_b      = node_ok(request.node_b, node_count);
  assign sum       = {1'b0, total} + (ufmst_pkg::TOTAL_BITS + 1)'(wt);

  assign done_next = (state == S_LINK) ||
                     ((state == S_CLR) && (cur == LAST) && clr_item) ||
                     (accept && (request.mode == ufmst_pkg::MODE_EDGE) &&
                      (!ok_a || !ok_b));

  assign result.joined       = joined;
  assign result.total_weight = total;
  assign result.edges_taken  = count;
  assign result.bad_node     = bad;

  always_comb begin
    raddr = cur;
    we    = 1'b0;
    waddr = cur;
    wdata = cur;
    unique case (state)
      S_CLR: begin
        we = 1'b1;
      end
      S_CRD: begin
        raddr = walk;
      end
      S_CWR: begin
        we    = 1'b1;
        waddr = walk;
      end
      S_LINK: begin
        we    = (root_a != cur);
        waddr = (root_a < cur) ? cur : root_a;
        wdata = (root_a < cur) ? root_a : cur;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      parent_mem[waddr] <= wdata;
    end
    rdata <= parent_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      cur        <= '0;
      side       <= 1'b0;
      clr_item   <= 1'b0;
      node_count <= ufmst_pkg::NODE_COUNT_RESET;
      total      <= '0;
      count      <= '0;
      done       <= 1'b0;
      joined     <= 1'b0;
      bad        <= 1'b0;
    end else begin
      done <= done_next;
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            joined <= 1'b0;
            bad    <= 1'b0;
            if (request.mode == ufmst_pkg::MODE_CLEAR) begin
              total    <= '0;
              count    <= '0;
              cur      <= '0;
              clr_item <= 1'b1;
              state    <= S_CLR;
            end else if (!ok_a || !ok_b) begin
              bad  <= 1'b1;
            end else begin
              cur    <= AW'(request.node_a);
              walk   <= AW'(request.node_a);
              addr_b <= AW'(request.node_b);
              wt     <= request.weight & WMASK;
              side   <= 1'b0;
              state  <= S_FIND;
            end
          end
        end
        S_CLR: begin
          if (cur == LAST) begin
            clr_item <= 1'b0;
            state    <= S_IDLE;
          end else begin
            cur <= cur + 1'b1;
          end
        end
        S_FIND: begin
          state <= S_FCHK;
        end
        S_FCHK: begin
          if (rdata == cur) begin
            state <= S_CRD;
          end else begin
            cur   <= rdata;
            state <= S_FIND;
          end
        end
        S_CRD: begin
          if (walk == cur) begin
            if (!side) begin
              root_a <= cur;
              cur    <= addr_b;
              walk   <= addr_b;
              side   <= 1'b1;
              state  <= S_FIND;
            end else begin
              state <= S_LINK;
            end
          end else begin
            state <= S_CWR;
          end
        end
        S_CWR: begin
          walk  <= rdata;
          state <= S_CRD;
        end
        S_LINK: begin
          if (root_a != cur) begin
            joined <= 1'b1;
            total  <= sum[ufmst_pkg::TOTAL_BITS] ? ufmst_pkg::TOTAL_MAX
                                                 : sum[ufmst_pkg::TOTAL_BITS-1:0];
            if (count != ufmst_pkg::COUNT_MAX) begin
              count <= count + 1'b1;
            end
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
